/* rtl/ipv4_l4_header_metadata_parser_core_defines.svh */
// assertion macros for the ipv4 l4 header metadata parser
// used by the top level only; no other dependencies
`ifndef IPV4_L4_HEADER_METADATA_PARSER_CORE_DEFINES_SVH
`define IPV4_L4_HEADER_METADATA_PARSER_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define IPL4_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define IPL4_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ipl4_pkg.sv */
// shared types and constants for the ipv4 l4 header metadata parser
// no dependencies
package ipl4_pkg;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [3:0]  IHL_PLAIN      = 4'd5;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [5:0]  UDP_HDR_BYTES  = 6'd8;
  localparam logic [6:0]  IP_HDR_BYTES   = 7'd20;
  localparam logic [16:0] WINDOW_NONE    = 17'h1FFFF;

  // byte positions within the frame
  localparam logic [5:0] POS_FIRST    = 6'd0;
  localparam logic [5:0] POS_ETYPE_HI = 6'd12;
  localparam logic [5:0] POS_ETYPE_LO = 6'd13;
  localparam logic [5:0] POS_VER_IHL  = 6'd14;
  localparam logic [5:0] POS_TLEN_HI  = 6'd16;
  localparam logic [5:0] POS_TLEN_LO  = 6'd17;
  localparam logic [5:0] POS_PROTO    = 6'd23;
  localparam logic [5:0] POS_SRC_FIRST = 6'd26;
  localparam logic [5:0] POS_SRC_LAST  = 6'd29;
  localparam logic [5:0] POS_DST_FIRST = 6'd30;
  localparam logic [5:0] POS_DST_LAST  = 6'd33;
  localparam logic [5:0] POS_SPORT_HI = 6'd34;
  localparam logic [5:0] POS_SPORT_LO = 6'd35;
  localparam logic [5:0] POS_DPORT_HI = 6'd36;
  localparam logic [5:0] POS_DPORT_LO = 6'd37;
  localparam logic [5:0] POS_UDP_DONE = 6'd41;
  localparam logic [5:0] POS_TCP_OFF  = 6'd46;
  localparam logic [5:0] POS_TCP_FLAG = 6'd47;
  localparam logic [5:0] POS_WIN_HI   = 6'd48;
  localparam logic [5:0] POS_WIN_LO   = 6'd49;
  localparam logic [5:0] POS_TCP_DONE = 6'd53;

  localparam int QUEUE_DEPTH_DEF = 2;

  // raw header capture handed from front to back
  typedef struct packed {
    logic [63:0] stamp;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] total_len;
    logic [7:0]  proto;
    logic [3:0]  data_off;
    logic [7:0]  flags;
    logic [15:0] window;
  } rec_t;

  typedef enum logic [1:0] {
    ST_HDR  = 2'b01,
    ST_SKIP = 2'b10
  } front_state_t;

endpackage

/* rtl/ipv4_l4_header_metadata_parser_core.sv */
// top level of the ipv4 l4 header metadata parser
// depends on ipl4_pkg, ipl4_front, ipl4_queue, ipl4_back and the defines header
//
// usage:
// - input channel: one ethernet frame byte per transaction, wire order from the
//   destination mac, in_frame_last on the final byte, in_time_us sampled on the
//   first byte. a transaction completes when in_push is high and in_full low.
// - result channel: one metadata record per ipv4 (ihl 5) tcp or udp frame that
//   reaches the end of its l4 header; the record sits on the out_ ports while
//   out_empty is low and leaves on a cycle with out_pop high.
// - throughput: one byte per cycle. the front capture logic takes a byte every
//   cycle; in_full rises only when the record queue between front and back is
//   full, which needs the result side to stall across two whole headers.
// - path: the record for the byte that completes the l4 header is written into
//   the queue and then loaded into the result register.
// - reset (synchronous, rst_n low): byte position returns to the first byte of a
//   frame, queue and result register empty. header fields need no reset.
// - a stalled result side only holds the result register and fills the queue;
//   bytes of frames that give no record keep flowing until in_full rises.
`include "ipv4_l4_header_metadata_parser_core_defines.svh"

module ipv4_l4_header_metadata_parser_core
  import ipl4_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_data_byte,
  input  logic               in_frame_last,
  input  logic [63:0]        in_time_us,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [63:0]        out_stamp_us,
  output logic [31:0]        out_source_addr,
  output logic [31:0]        out_dest_addr,
  output logic signed [16:0] out_recv_window,
  output logic [15:0]        out_source_port,
  output logic [15:0]        out_dest_port,
  output logic [15:0]        out_payload_bytes,
  output logic [5:0]         out_l4_header_bytes,
  output logic [7:0]         out_ip_protocol,
  output logic [7:0]         out_tcp_flag_bits
);

  logic byte_take;
  logic front_valid;
  rec_t front_rec;
  logic q_full;
  logic q_valid;
  rec_t q_rec;
  logic q_take;
  logic res_valid;

  assign in_full   = q_full;
  assign byte_take = in_push && !q_full;
  assign out_empty = !res_valid;

  ipl4_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_take  (byte_take),
    .data_byte  (in_data_byte),
    .frame_last (in_frame_last),
    .time_us    (in_time_us),
    .rec_valid  (front_valid),
    .rec        (front_rec)
  );

  ipl4_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (front_valid),
    .wr_rec   (front_rec),
    .full     (q_full),
    .rd_en    (q_take),
    .rd_valid (q_valid),
    .rd_rec   (q_rec)
  );

  ipl4_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .rec_valid       (q_valid),
    .rec             (q_rec),
    .rec_take        (q_take),
    .res_valid       (res_valid),
    .res_pop         (out_pop),
    .stamp_us        (out_stamp_us),
    .source_addr     (out_source_addr),
    .dest_addr       (out_dest_addr),
    .recv_window     (out_recv_window),
    .source_port     (out_source_port),
    .dest_port       (out_dest_port),
    .payload_bytes   (out_payload_bytes),
    .l4_header_bytes (out_l4_header_bytes),
    .ip_protocol     (out_ip_protocol),
    .tcp_flag_bits   (out_tcp_flag_bits)
  );

  // records are separated by at least a full header, never back to back
  `IPL4_ASSERT_NEXT(a_no_adjacent_records, clk, rst_n, front_valid, !front_valid, "two records on adjacent cycles")
  // a record must never be written into a full queue
  `IPL4_ASSERT_NOW(a_no_write_when_full, clk, rst_n, front_valid, !q_full, "record written into full queue")
  // only tcp or udp frames reach the result side
  `IPL4_ASSERT_NOW(a_result_proto, clk, rst_n, !out_empty, (out_ip_protocol == PROTO_TCP) || (out_ip_protocol == PROTO_UDP), "result with unexpected protocol")

endmodule

/* rtl/ipl4_front.sv */
// front part: tracks byte position, captures header fields, classifies the frame
// depends on ipl4_pkg
module ipl4_front
  import ipl4_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_take,
  input  logic [7:0] data_byte,
  input  logic       frame_last,
  input  logic [63:0] time_us,
  output logic       rec_valid,
  output rec_t       rec
);

  front_state_t state_r, state_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [63:0] stamp_r;
  logic [7:0]  etype_hi_r;
  logic [15:0] tlen_r;
  logic [7:0]  proto_r;
  logic [31:0] src_r;
  logic [31:0] dst_r;
  logic [15:0] sport_r;
  logic [15:0] dport_r;
  logic [3:0]  off_r;
  logic [7:0]  flags_r;
  logic [15:0] win_r;

  logic work;
  logic reject;
  logic emit;

  assign work = byte_take && (state_r == ST_HDR);

  always_comb begin
    reject = 1'b0;
    if (pos_r == POS_ETYPE_LO && {etype_hi_r, data_byte} != ETHERTYPE_IPV4) begin
      reject = 1'b1;
    end
    if (pos_r == POS_VER_IHL && data_byte[3:0] != IHL_PLAIN) begin
      reject = 1'b1;
    end
    if (pos_r == POS_PROTO && data_byte != PROTO_TCP && data_byte != PROTO_UDP) begin
      reject = 1'b1;
    end
  end

  assign emit = (pos_r == POS_UDP_DONE && proto_r == PROTO_UDP) || (pos_r == POS_TCP_DONE);
  assign rec_valid = work && emit;

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    if (work) begin
      if (reject || emit) begin
        state_nxt = ST_SKIP;
      end else begin
        pos_nxt = pos_r + 6'd1;
      end
    end
    if (byte_take && frame_last) begin
      state_nxt = ST_HDR;
      pos_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HDR;
      pos_r   <= '0;
      stamp_r <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      if (work && pos_r == POS_FIRST) begin
        stamp_r <= time_us;
      end
    end
  end

  // header field capture, shifted in big-endian by position
  always_ff @(posedge clk) begin
    if (work) begin
      if (pos_r == POS_ETYPE_HI) begin
        etype_hi_r <= data_byte;
      end
      if (pos_r == POS_TLEN_HI || pos_r == POS_TLEN_LO) begin
        tlen_r <= {tlen_r[7:0], data_byte};
      end
      if (pos_r == POS_PROTO) begin
        proto_r <= data_byte;
      end
      if (pos_r >= POS_SRC_FIRST && pos_r <= POS_SRC_LAST) begin
        src_r <= {src_r[23:0], data_byte};
      end
      if (pos_r >= POS_DST_FIRST && pos_r <= POS_DST_LAST) begin
        dst_r <= {dst_r[23:0], data_byte};
      end
      if (pos_r == POS_SPORT_HI || pos_r == POS_SPORT_LO) begin
        sport_r <= {sport_r[7:0], data_byte};
      end
      if (pos_r == POS_DPORT_HI || pos_r == POS_DPORT_LO) begin
        dport_r <= {dport_r[7:0], data_byte};
      end
      if (pos_r == POS_TCP_OFF) begin
        off_r <= data_byte[7:4];
      end
      if (pos_r == POS_TCP_FLAG) begin
        flags_r <= data_byte;
      end
      if (pos_r == POS_WIN_HI || pos_r == POS_WIN_LO) begin
        win_r <= {win_r[7:0], data_byte};
      end
    end
  end

  always_comb begin
    rec.stamp     = stamp_r;
    rec.src_addr  = src_r;
    rec.dst_addr  = dst_r;
    rec.src_port  = sport_r;
    rec.dst_port  = dport_r;
    rec.total_len = tlen_r;
    rec.proto     = proto_r;
    rec.data_off  = off_r;
    rec.flags     = flags_r;
    rec.window    = win_r;
  end

endmodule

/* rtl/ipl4_queue.sv */
// short record queue between front and back parts
// depends on ipl4_pkg
module ipl4_queue
  import ipl4_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
)(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  rec_t wr_rec,
  output logic full,
  input  logic rd_en,
  output logic rd_valid,
  output rec_t rd_rec
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rec_t slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_rec   = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots_r[wr_ptr_r] <= wr_rec;
    end
  end

endmodule

/* rtl/ipl4_back.sv */
// back part: derives lengths, window and flags, holds the result register
// depends on ipl4_pkg
module ipl4_back
  import ipl4_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rec_valid,
  input  rec_t               rec,
  output logic               rec_take,
  output logic               res_valid,
  input  logic               res_pop,
  output logic [63:0]        stamp_us,
  output logic [31:0]        source_addr,
  output logic [31:0]        dest_addr,
  output logic signed [16:0] recv_window,
  output logic [15:0]        source_port,
  output logic [15:0]        dest_port,
  output logic [15:0]        payload_bytes,
  output logic [5:0]         l4_header_bytes,
  output logic [7:0]         ip_protocol,
  output logic [7:0]         tcp_flag_bits
);

  logic        valid_r;
  logic        is_tcp;
  logic [5:0]  l4_len;
  logic [15:0] used;
  logic [15:0] payload;
  logic [16:0] window;
  logic [7:0]  flags;

  logic [63:0] stamp_r;
  logic [31:0] src_r;
  logic [31:0] dst_r;
  logic [16:0] win_r;
  logic [15:0] sport_r;
  logic [15:0] dport_r;
  logic [15:0] payload_r;
  logic [5:0]  l4_len_r;
  logic [7:0]  proto_r;
  logic [7:0]  flags_r;

  assign rec_take = rec_valid && (!valid_r || res_pop);

  assign is_tcp = (rec.proto == PROTO_TCP);
  assign l4_len = is_tcp ? {rec.data_off, 2'b00} : UDP_HDR_BYTES;
  assign used   = 16'(IP_HDR_BYTES) + 16'(l4_len);
  // floored at zero
  assign payload = (rec.total_len > used) ? (rec.total_len - used) : '0;
  assign window  = is_tcp ? {1'b0, rec.window} : WINDOW_NONE;
  assign flags   = is_tcp ? rec.flags : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (rec_take) begin
      valid_r <= 1'b1;
    end else if (res_pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_take) begin
      stamp_r   <= rec.stamp;
      src_r     <= rec.src_addr;
      dst_r     <= rec.dst_addr;
      win_r     <= window;
      sport_r   <= rec.src_port;
      dport_r   <= rec.dst_port;
      payload_r <= payload;
      l4_len_r  <= l4_len;
      proto_r   <= rec.proto;
      flags_r   <= flags;
    end
  end

  assign res_valid       = valid_r;
  assign stamp_us        = stamp_r;
  assign source_addr     = src_r;
  assign dest_addr       = dst_r;
  assign recv_window     = win_r;
  assign source_port     = sport_r;
  assign dest_port       = dport_r;
  assign payload_bytes   = payload_r;
  assign l4_header_bytes = l4_len_r;
  assign ip_protocol     = proto_r;
  assign tcp_flag_bits   = flags_r;

endmodule
